FILE: rtl/ccnt_pkg.sv
// ccnt_pkg: shared widths, pipeline stage map, control struct and the
// constant-divide digit helpers for the coulomb counter.
// No dependencies.
`default_nettype none

package ccnt_pkg;

  localparam int unsigned CurW    = 24;
  localparam int unsigned TickW   = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned ProdW   = 56;
  localparam int unsigned MahW    = 32;
  localparam int unsigned CfgIdxW = 2;

  // stage map: input, elapsed time, product, accumulate, 6 divide, result
  localparam int unsigned DivStg  = 6;
  localparam int unsigned StgIn   = 0;
  localparam int unsigned StgDt   = 1;
  localparam int unsigned StgProd = 2;
  localparam int unsigned StgAcc  = 3;
  localparam int unsigned StgDiv  = 4;
  localparam int unsigned StgOut  = StgDiv + DivStg;
  localparam int unsigned NStg    = StgOut + 1;

  // 3600000 = 2^7 * 28125; the odd part is divided 16 bits per digit
  localparam int unsigned DivShift   = 7;
  localparam int unsigned DivOdd     = 28125;
  localparam int unsigned DigitW     = 16;
  localparam int unsigned RemW       = 15;
  localparam int unsigned ValW       = RemW + DigitW;
  localparam int unsigned RecipShift = ValW;
  localparam int unsigned RecipW     = 17;
  localparam int unsigned RecipM     = (2**RecipShift) / DivOdd;
  localparam int unsigned EstProdW   = ValW + RecipW;

  typedef logic [CfgIdxW-1:0] reg_idx_t;
  localparam reg_idx_t RegBaseDis = reg_idx_t'(0);
  localparam reg_idx_t RegBaseChg = reg_idx_t'(1);

  typedef struct packed {
    logic [NStg-1:0] adv;  // stage captures this cycle
    logic [NStg-1:0] vld;  // stage holds a word
  } ctrl_t;

  typedef struct packed {
    logic [DigitW-1:0] q;
    logic [RemW-1:0]   r;
  } digit_t;

  // quotient estimate, equal to the true digit or one below
  function automatic logic [DigitW-1:0] digit_est(input logic [ValW-1:0] val);
    logic [EstProdW-1:0] prod;
    prod = EstProdW'(val) * EstProdW'(RecipM);
    return prod[RecipShift +: DigitW];
  endfunction

  function automatic digit_t digit_fix(input logic [ValW-1:0]   val,
                                       input logic [DigitW-1:0] est);
    logic [ValW-1:0] rem;
    digit_t          res;
    rem = val - ValW'(est) * ValW'(DivOdd);
    if (rem >= ValW'(DivOdd)) begin
      res.q = est + DigitW'(1);
      res.r = RemW'(rem - ValW'(DivOdd));
    end else begin
      res.q = est;
      res.r = RemW'(rem);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ccnt_if.sv
// ccnt_if: valid/ready channel interfaces for samples, results and
// configuration writes. Depends on ccnt_pkg.
`default_nettype none

interface ccnt_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [ccnt_pkg::CurW-1:0] current_ma;
  logic [ccnt_pkg::TickW-1:0]       now_ms;
  modport source (output valid, current_ma, now_ms, input ready);
  modport sink   (input valid, current_ma, now_ms, output ready);
endinterface

interface ccnt_result_if;
  logic                      valid;
  logic                      ready;
  logic                      valid_res;
  logic [ccnt_pkg::MahW-1:0] session_discharged_mah;
  logic [ccnt_pkg::MahW-1:0] session_charged_mah;
  logic [ccnt_pkg::MahW-1:0] lifetime_discharged_mah;
  logic [ccnt_pkg::MahW-1:0] lifetime_charged_mah;
  modport source (output valid, valid_res, session_discharged_mah, session_charged_mah,
                  lifetime_discharged_mah, lifetime_charged_mah, input ready);
  modport sink   (input valid, valid_res, session_discharged_mah, session_charged_mah,
                  lifetime_discharged_mah, lifetime_charged_mah, output ready);
endinterface

interface ccnt_cfg_if;
  logic                      valid;
  logic                      ready;
  ccnt_pkg::reg_idx_t        addr;
  logic [ccnt_pkg::MahW-1:0] wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/ccnt_pipe_ctrl.sv
// ccnt_pipe_ctrl: per-stage valid bits and capture enables; bubbles
// collapse, a stalled result backs up only the stages behind it.
// Depends on ccnt_pkg.
`default_nettype none

module ccnt_pipe_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            out_ready_i,
  output ccnt_pkg::ctrl_t      ctrl_o,
  output logic                 in_ready_o,
  output logic                 out_valid_o
);

  logic [ccnt_pkg::NStg-1:0] vld_q, vld_d, free, up;

  always_comb begin
    free[ccnt_pkg::NStg-1] = !vld_q[ccnt_pkg::NStg-1] || out_ready_i;
    for (int k = ccnt_pkg::NStg - 2; k >= 0; k--) begin
      free[k] = !vld_q[k] || free[k+1];
    end
  end

  assign up    = {vld_q[ccnt_pkg::NStg-2:0], in_valid_i};
  assign vld_d = (free & up) | (~free & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl_o.adv  = free;
  assign ctrl_o.vld  = vld_q;
  assign in_ready_o  = free[ccnt_pkg::StgIn];
  assign out_valid_o = vld_q[ccnt_pkg::StgOut];

  // a full stage that cannot pass its word on keeps it
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(vld_q & ~free) & ~vld_q) == '0))
    else $error("stalled word dropped from pipeline");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && free[ccnt_pkg::StgIn]) |=> vld_q[ccnt_pkg::StgIn])
    else $error("accepted word not held in input stage");

endmodule

`default_nettype wire

FILE: rtl/ccnt_integrator.sv
// ccnt_integrator: input register, elapsed-time and prime logic,
// magnitude times elapsed ms, and the two 64-bit accumulators.
// Depends on ccnt_pkg.
`default_nettype none

module ccnt_integrator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ccnt_pkg::ctrl_t                  ctrl_i,
  input  wire logic signed [ccnt_pkg::CurW-1:0] current_ma_i,
  input  wire logic [ccnt_pkg::TickW-1:0]       now_ms_i,
  output logic [ccnt_pkg::AccW-1:0]             dis_acc_o,
  output logic [ccnt_pkg::AccW-1:0]             chg_acc_o,
  output logic                                  res_o
);

  logic [ccnt_pkg::CurW-1:0]  cur0_q;
  logic [ccnt_pkg::TickW-1:0] now0_q;

  logic                       primed_q, primed_d;
  logic [ccnt_pkg::TickW-1:0] last_tick_q, last_tick_d;
  logic [ccnt_pkg::TickW-1:0] dt;
  logic [ccnt_pkg::CurW-1:0]  mag;
  logic                       res1_d;

  logic [ccnt_pkg::TickW-1:0] dt1_q;
  logic [ccnt_pkg::CurW-1:0]  mag1_q;
  logic                       dis1_q, res1_q;

  logic [ccnt_pkg::ProdW-1:0] prod2_q;
  logic                       dis2_q, res2_q;

  logic [ccnt_pkg::AccW-1:0]  dis_acc_q, chg_acc_q;
  logic                       res3_q;
  logic                       take1, take3;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[ccnt_pkg::StgIn]) begin
      cur0_q <= current_ma_i;
      now0_q <= now_ms_i;
    end
  end

  assign take1 = ctrl_i.adv[ccnt_pkg::StgDt] && ctrl_i.vld[ccnt_pkg::StgIn];
  assign dt    = now0_q - last_tick_q;
  assign mag   = cur0_q[ccnt_pkg::CurW-1] ? (ccnt_pkg::CurW'(0) - cur0_q) : cur0_q;

  always_comb begin
    primed_d    = primed_q;
    last_tick_d = last_tick_q;
    res1_d      = 1'b0;
    if (take1) begin
      if (!primed_q) begin
        primed_d    = 1'b1;
        last_tick_d = now0_q;
      end else if (dt != '0) begin
        last_tick_d = now0_q;
        res1_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      last_tick_q <= '0;
    end else begin
      primed_q    <= primed_d;
      last_tick_q <= last_tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[ccnt_pkg::StgDt]) begin
      dt1_q  <= dt;
      mag1_q <= mag;
      dis1_q <= cur0_q[ccnt_pkg::CurW-1];
      res1_q <= res1_d;
    end
    if (ctrl_i.adv[ccnt_pkg::StgProd]) begin
      prod2_q <= ccnt_pkg::ProdW'(mag1_q) * ccnt_pkg::ProdW'(dt1_q);
      dis2_q  <= dis1_q;
      res2_q  <= res1_q;
    end
    if (ctrl_i.adv[ccnt_pkg::StgAcc]) begin
      res3_q <= res2_q;
    end
  end

  // the accumulators double as the accumulate stage's payload
  assign take3 = ctrl_i.adv[ccnt_pkg::StgAcc] && ctrl_i.vld[ccnt_pkg::StgProd] && res2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dis_acc_q <= '0;
      chg_acc_q <= '0;
    end else if (take3) begin
      if (dis2_q) begin
        dis_acc_q <= dis_acc_q + ccnt_pkg::AccW'(prod2_q);
      end else begin
        chg_acc_q <= chg_acc_q + ccnt_pkg::AccW'(prod2_q);
      end
    end
  end

  assign dis_acc_o = dis_acc_q;
  assign chg_acc_o = chg_acc_q;
  assign res_o     = res3_q;

  a_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take1 |=> primed_q)
    else $error("sample passed without priming");

  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take3 |=> ($stable(dis_acc_q) && $stable(chg_acc_q)))
    else $error("accumulator moved without an integrating sample");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take3 |=> ($stable(dis_acc_q) || $stable(chg_acc_q)))
    else $error("both accumulators moved on one sample");

endmodule

`default_nettype wire

FILE: rtl/ccnt_const_div.sv
// ccnt_const_div: six-stage divide of a 64-bit word by 3600000, low 32
// quotient bits; shift by 7, then three 16-bit digits by 28125.
// Depends on ccnt_pkg.
`default_nettype none

module ccnt_const_div (
  input  wire logic                           clk_i,
  input  wire logic [ccnt_pkg::DivStg-1:0]    adv_i,
  input  wire logic [ccnt_pkg::AccW-1:0]      acc_i,
  output logic [ccnt_pkg::MahW-1:0]           quot_o
);

  localparam int unsigned DW = ccnt_pkg::DigitW;
  localparam int unsigned VW = ccnt_pkg::ValW;
  localparam int unsigned RW = ccnt_pkg::RemW;
  // top bits of the shifted word form the first digit; only its remainder
  // is kept, its quotient lands above the 32 result bits
  localparam int unsigned HeadLo = ccnt_pkg::DivShift + 2 * DW;

  logic [VW-1:0]   val1, val2, val3;
  logic [VW-1:0]   val1_q, val2_q, val3_q;
  logic [DW-1:0]   est1_q, est2_q, est3_q;
  logic [2*DW-1:0] low1_q, low2_q;
  logic [DW-1:0]   low3_q, low4_q;
  logic [RW-1:0]   r1_q, r2_q;
  logic [DW-1:0]   q2_q, q2b_q;
  logic [2*DW-1:0] quot_q;
  ccnt_pkg::digit_t fix1, fix2, fix3;

  assign val1 = VW'(acc_i[ccnt_pkg::AccW-1:HeadLo]);
  assign val2 = {r1_q, low2_q[2*DW-1:DW]};
  assign val3 = {r2_q, low4_q};
  assign fix1 = ccnt_pkg::digit_fix(val1_q, est1_q);
  assign fix2 = ccnt_pkg::digit_fix(val2_q, est2_q);
  assign fix3 = ccnt_pkg::digit_fix(val3_q, est3_q);

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      val1_q <= val1;
      est1_q <= ccnt_pkg::digit_est(val1);
      low1_q <= acc_i[HeadLo-1:ccnt_pkg::DivShift];
    end
    if (adv_i[1]) begin
      r1_q   <= fix1.r;
      low2_q <= low1_q;
    end
    if (adv_i[2]) begin
      val2_q <= val2;
      est2_q <= ccnt_pkg::digit_est(val2);
      low3_q <= low2_q[DW-1:0];
    end
    if (adv_i[3]) begin
      r2_q   <= fix2.r;
      q2_q   <= fix2.q;
      low4_q <= low3_q;
    end
    if (adv_i[4]) begin
      val3_q <= val3;
      est3_q <= ccnt_pkg::digit_est(val3);
      q2b_q  <= q2_q;
    end
    if (adv_i[5]) begin
      quot_q <= {q2b_q, fix3.q};
    end
  end

  assign quot_o = ccnt_pkg::MahW'(quot_q);

endmodule

`default_nettype wire

FILE: rtl/coulomb_counter_core.sv
// coulomb_counter_core: top level; baseline registers, result stage and
// wiring. Depends on ccnt_pkg, ccnt_if, ccnt_pipe_ctrl, ccnt_integrator,
// ccnt_const_div.
//
//   port      dir   fields
//   sample_i  sink  current_ma (s24), now_ms (u32)
//   result_o  src   valid_res, session/lifetime discharged/charged mAh (u32)
//   cfg_i     sink  addr (0 baseline discharged, 1 baseline charged), wdata
//
// Sustained rate is one word per clock while result_o is ready; a sample passes
// the input, elapsed-time, product, accumulate, divide and result stages.
// Reset clears control state, accumulators and baselines; no clearing pass.
// A stalled result_o backs up only the full stages behind it; empty stages
// keep taking words. cfg_i is always ready.
`default_nettype none

module coulomb_counter_core (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ccnt_sample_if.sink   sample_i,
  ccnt_result_if.source result_o,
  ccnt_cfg_if.sink      cfg_i
);

  ccnt_pkg::ctrl_t ctrl;

  logic [ccnt_pkg::AccW-1:0] dis_acc, chg_acc;
  logic                      res3;
  logic [ccnt_pkg::MahW-1:0] quot_dis, quot_chg;
  logic [ccnt_pkg::DivStg-1:0] res_q;
  logic [ccnt_pkg::MahW-1:0] base_dis_q, base_chg_q;

  logic                      valid_res_q;
  logic [ccnt_pkg::MahW-1:0] sess_dis_q, sess_chg_q, life_dis_q, life_chg_q;
  logic                      res_last;

  ccnt_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .out_ready_i (result_o.ready),
    .ctrl_o      (ctrl),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid)
  );

  ccnt_integrator u_integ (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .current_ma_i (sample_i.current_ma),
    .now_ms_i     (sample_i.now_ms),
    .dis_acc_o    (dis_acc),
    .chg_acc_o    (chg_acc),
    .res_o        (res3)
  );

  ccnt_const_div u_div_dis (
    .clk_i  (clk_i),
    .adv_i  (ctrl.adv[ccnt_pkg::StgDiv +: ccnt_pkg::DivStg]),
    .acc_i  (dis_acc),
    .quot_o (quot_dis)
  );

  ccnt_const_div u_div_chg (
    .clk_i  (clk_i),
    .adv_i  (ctrl.adv[ccnt_pkg::StgDiv +: ccnt_pkg::DivStg]),
    .acc_i  (chg_acc),
    .quot_o (quot_chg)
  );

  // result flag rides alongside the divide stages
  always_ff @(posedge clk_i) begin
    if (ctrl.adv[ccnt_pkg::StgDiv]) begin
      res_q[0] <= res3;
    end
    for (int k = 1; k < ccnt_pkg::DivStg; k++) begin
      if (ctrl.adv[ccnt_pkg::StgDiv + k]) begin
        res_q[k] <= res_q[k-1];
      end
    end
  end

  assign res_last = res_q[ccnt_pkg::DivStg-1];

  always_ff @(posedge clk_i) begin
    if (ctrl.adv[ccnt_pkg::StgOut]) begin
      valid_res_q <= res_last;
      sess_dis_q  <= res_last ? quot_dis : '0;
      sess_chg_q  <= res_last ? quot_chg : '0;
      life_dis_q  <= res_last ? (base_dis_q + quot_dis) : '0;
      life_chg_q  <= res_last ? (base_chg_q + quot_chg) : '0;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_dis_q <= '0;
      base_chg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        ccnt_pkg::RegBaseDis: base_dis_q <= cfg_i.wdata;
        ccnt_pkg::RegBaseChg: base_chg_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign result_o.valid_res               = valid_res_q;
  assign result_o.session_discharged_mah  = sess_dis_q;
  assign result_o.session_charged_mah     = sess_chg_q;
  assign result_o.lifetime_discharged_mah = life_dis_q;
  assign result_o.lifetime_charged_mah    = life_chg_q;

  // input side only blocks when the whole pipeline is backed up by result_o
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (result_o.valid && !result_o.ready))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
